// ===== design/hkmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Hotkey match table package
// Shared types, command and status codes, and default sizes.
// ----------------------------------------------------------------------------
package hkmt_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_WIDTH = 16;
   localparam int MOD_WIDTH = 8;
   localparam int ENTRY_WIDTH = KEY_WIDTH + MOD_WIDTH;

   typedef enum logic [1:0] {
      CMD_FIND   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_SPARE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_PRESENT   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [KEY_WIDTH-1:0] key_code;
      logic [MOD_WIDTH-1:0] modifier_bits;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       ok;
      logic [3:0] match_index;
      logic [4:0] entry_count;
   } rsp_type;

endpackage

// ===== design/hkmt_ram.sv =====
// ----------------------------------------------------------------------------
// Hotkey match table RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module hkmt_ram #(
   parameter int WIDTH = hkmt_pkg::ENTRY_WIDTH,
   parameter int DEPTH = hkmt_pkg::DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hotkey_match_table.sv =====
// ----------------------------------------------------------------------------
// Hotkey match table
// Ordered table of key and modifier pairs with find, add and remove commands.
// A request is taken only in the idle state. The table is scanned from entry 0
// until a hit or the end of the used entries; a remove hit then moves the later
// entries down one place. One command is in flight at a time, and the next
// request transfer can follow in the cycle after the response transfer.
// Reset empties the table; entry contents are not cleared.
// ----------------------------------------------------------------------------
module hotkey_match_table #(
   parameter int DEPTH = hkmt_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hkmt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hkmt_pkg::rsp_type rsp_data
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type                        state_ff, state_in;
   hkmt_pkg::req_type                req_ff, req_in;
   hkmt_pkg::rsp_type                rsp_ff, rsp_in;
   logic [CW-1:0]                    used_ff, used_in;
   logic [CW-1:0]                    rd_idx_ff, rd_idx_in;
   logic                             pend_ff, pend_in;
   logic [IW-1:0]                    pend_idx_ff, pend_idx_in;
   logic [IW-1:0]                    pos_ff, pos_in;

   logic                             wr_en;
   logic [IW-1:0]                    wr_addr;
   logic [hkmt_pkg::ENTRY_WIDTH-1:0] wr_data;
   logic                             rd_en;
   logic [hkmt_pkg::ENTRY_WIDTH-1:0] rd_data;
   logic                             hit;
   logic                             more;
   logic [31:0]                      pos_wide;
   logic [31:0]                      count_wide;

   hkmt_ram #(
      .WIDTH (hkmt_pkg::ENTRY_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign hit  = pend_ff && (rd_data == {req_ff.key_code, req_ff.modifier_bits});
   assign more = (rd_idx_ff < used_ff);

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      rsp_in      = rsp_ff;
      used_in     = used_ff;
      rd_idx_in   = rd_idx_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      pos_in      = pos_ff;
      wr_en       = 1'b0;
      wr_addr     = pend_idx_ff - IW'(1);
      wr_data     = rd_data;
      rd_en       = 1'b0;
      pos_wide    = 32'(pend_idx_ff);
      count_wide  = 32'(used_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               rd_idx_in = '0;
               pend_in   = 1'b0;
               state_in  = S_SCAN;
            end
         end

         S_SCAN: begin
            if (hit) begin
               rsp_in.ok          = 1'b1;
               rsp_in.match_index = pos_wide[3:0];
               rsp_in.entry_count = count_wide[4:0];
               if (req_ff.cmd == hkmt_pkg::CMD_REMOVE) begin
                  pos_in    = pend_idx_ff;
                  rd_idx_in = CW'(pend_idx_ff) + CW'(1);
                  pend_in   = 1'b0;
                  state_in  = S_SHIFT;
               end else begin
                  if (req_ff.cmd == hkmt_pkg::CMD_ADD) begin
                     rsp_in.status = hkmt_pkg::ST_PRESENT;
                  end else begin
                     rsp_in.status = hkmt_pkg::ST_DONE;
                  end
                  state_in = S_RESP;
               end
            end else if (!pend_ff && !more) begin
               rsp_in.status      = hkmt_pkg::ST_NOT_FOUND;
               rsp_in.ok          = 1'b0;
               rsp_in.match_index = '0;
               rsp_in.entry_count = count_wide[4:0];
               if (req_ff.cmd == hkmt_pkg::CMD_ADD) begin
                  if (used_ff == CW'(DEPTH)) begin
                     rsp_in.status = hkmt_pkg::ST_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     wr_addr            = used_ff[IW-1:0];
                     wr_data            = {req_ff.key_code, req_ff.modifier_bits};
                     used_in            = used_ff + CW'(1);
                     count_wide         = 32'(used_in);
                     rsp_in.status      = hkmt_pkg::ST_DONE;
                     rsp_in.ok          = 1'b1;
                     rsp_in.match_index = count_wide[3:0] - 4'd1;
                     rsp_in.entry_count = count_wide[4:0];
                  end
               end
               state_in = S_RESP;
            end else begin
               pend_in     = more;
               pend_idx_in = rd_idx_ff[IW-1:0];
               if (more) begin
                  rd_en     = 1'b1;
                  rd_idx_in = rd_idx_ff + CW'(1);
               end
            end
         end

         S_SHIFT: begin
            wr_en       = pend_ff;
            pend_in     = more;
            pend_idx_in = rd_idx_ff[IW-1:0];
            if (more) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (!pend_ff && !more) begin
               used_in            = used_ff - CW'(1);
               count_wide         = 32'(used_in);
               pos_wide           = 32'(pos_ff);
               rsp_in.status      = hkmt_pkg::ST_DONE;
               rsp_in.ok          = 1'b1;
               rsp_in.match_index = pos_wide[3:0];
               rsp_in.entry_count = count_wide[4:0];
               state_in           = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

endmodule
